>>> sv/bssv_pkg.sv
// Shared widths, types and elaboration helpers for the block SAD/SSE/variance core.
`timescale 1ns / 1ps

package bssv_pkg;

	// Fixed field widths
	localparam int PIX_W       = 8;
	localparam int ABS_W       = 16;
	localparam int SQ_W        = 24;
	localparam int SGN_W       = 18;
	localparam int CFG_W       = 3;
	localparam int PORT_LANES  = 4;
	localparam int PROD_W      = 2 * SGN_W;

	// Per-lane partial sums, widest case of four lanes
	localparam int LSUM_ABS_W  = PIX_W + 2;
	localparam int LSUM_SQ_W   = 2 * PIX_W + 2;
	localparam int LSUM_SGN_W  = PIX_W + 3;

	// Parameter defaults
	localparam int DEF_LANES    = 4;
	localparam int DEF_MAX_SIDE = 16;

	// Smallest legal side_log2
	localparam logic [CFG_W-1:0] MIN_SIDE_LOG2 = 3'd2;

	// One lane's difference terms
	typedef struct packed {
		logic        [PIX_W-1:0]   ad;
		logic        [2*PIX_W-1:0] sq;
		logic signed [PIX_W:0]     diff;
	} lane_res_t;

	// Block totals handed from the accumulator to the variance stage
	typedef struct packed {
		logic        [ABS_W-1:0] abs_sum;
		logic        [SQ_W-1:0]  sq_sum;
		logic signed [SGN_W-1:0] sgn_sum;
	} blk_res_t;

	// log2 of the largest supported side, clamped to 2..4
	function automatic int max_log2(input int max_side);
		int l;
		l = 0;
		for (int i = 0; i < 4; i++) begin
			if ((2 << l) <= max_side) begin
				l = l + 1;
			end
		end
		return (l < 2) ? 2 : l;
	endfunction

endpackage

>>> sv/bssv_lane.sv
// One pixel lane: difference, absolute difference and square, registered.
`timescale 1ns / 1ps

module bssv_lane (
	input  logic                          clk,
	input  logic                          en,
	input  logic                          use_lane,
	input  logic [bssv_pkg::PIX_W-1:0]    src,
	input  logic [bssv_pkg::PIX_W-1:0]    pred,
	output bssv_pkg::lane_res_t           res_s1
);
	import bssv_pkg::*;

	logic signed [PIX_W:0]   diff;
	logic        [PIX_W-1:0] ad;

	// Signed difference and its magnitude
	always_comb begin
		diff = signed'({1'b0, src}) - signed'({1'b0, pred});
		ad   = diff[PIX_W] ? PIX_W'(-diff) : diff[PIX_W-1:0];
	end

	// Lanes past the end of the block contribute zero
	always_ff @(posedge clk) begin
		if (en) begin
			if (use_lane) begin
				res_s1.ad   <= ad;
				res_s1.sq   <= ad * ad;
				res_s1.diff <= diff;
			end else begin
				res_s1 <= '0;
			end
		end
	end

endmodule

>>> sv/bssv_accum.sv
// Lane merge and block accumulators; hands block totals to the variance stage.
`timescale 1ns / 1ps

module bssv_accum #(
	parameter int LANES = bssv_pkg::DEF_LANES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clr,
	input  logic                 valid_s1,
	input  logic                 last_s1,
	input  bssv_pkg::lane_res_t  lane_s1 [LANES],
	output logic                 take_s1,
	input  logic                 nxt_ready,
	output logic                 valid_s2,
	output bssv_pkg::blk_res_t   res_s2
);
	import bssv_pkg::*;

	logic        [ABS_W-1:0]      abs_acc_q;
	logic        [SQ_W-1:0]       sq_acc_q;
	logic signed [SGN_W-1:0]      sgn_acc_q;
	logic        [LSUM_ABS_W-1:0] abs_sum;
	logic        [LSUM_SQ_W-1:0]  sq_sum;
	logic signed [LSUM_SGN_W-1:0] sgn_sum;
	logic        [ABS_W-1:0]      abs_nxt;
	logic        [SQ_W-1:0]       sq_nxt;
	logic signed [SGN_W-1:0]      sgn_nxt;
	logic                         rdy2;

	// Merge the lanes
	always_comb begin
		abs_sum = '0;
		sq_sum  = '0;
		sgn_sum = '0;
		for (int i = 0; i < LANES; i++) begin
			abs_sum = abs_sum + LSUM_ABS_W'(lane_s1[i].ad);
			sq_sum  = sq_sum + LSUM_SQ_W'(lane_s1[i].sq);
			sgn_sum = sgn_sum + LSUM_SGN_W'(lane_s1[i].diff);
		end
		abs_nxt = abs_acc_q + ABS_W'(abs_sum);
		sq_nxt  = sq_acc_q + SQ_W'(sq_sum);
		sgn_nxt = sgn_acc_q + SGN_W'(sgn_sum);
	end

	// Only the block-ending item needs room downstream
	assign rdy2    = !valid_s2 || nxt_ready;
	assign take_s1 = valid_s1 && (!last_s1 || rdy2);

	// Accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_acc_q <= '0;
			sq_acc_q  <= '0;
			sgn_acc_q <= '0;
		end else if (clr || (take_s1 && last_s1)) begin
			abs_acc_q <= '0;
			sq_acc_q  <= '0;
			sgn_acc_q <= '0;
		end else if (take_s1) begin
			abs_acc_q <= abs_nxt;
			sq_acc_q  <= sq_nxt;
			sgn_acc_q <= sgn_nxt;
		end
	end

	// Block totals register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (nxt_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && last_s1) begin
			res_s2.abs_sum <= abs_nxt;
			res_s2.sq_sum  <= sq_nxt;
			res_s2.sgn_sum <= sgn_nxt;
		end
	end

endmodule

>>> sv/bssv_var.sv
// Variance: square of the difference sum, scale by pixel count, subtract; output register.
`timescale 1ns / 1ps

module bssv_var (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bssv_pkg::CFG_W-1:0]    side_log2,
	input  logic                          valid_s2,
	input  bssv_pkg::blk_res_t            res_s2,
	output logic                          rdy3,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bssv_pkg::ABS_W-1:0]    abs_diff_total,
	output logic [bssv_pkg::SQ_W-1:0]     sq_diff_total,
	output logic [bssv_pkg::SQ_W-1:0]     block_variance
);
	import bssv_pkg::*;

	logic              valid_s3;
	logic [ABS_W-1:0]  abs_s3;
	logic [SQ_W-1:0]   sq_s3;
	logic [PROD_W-1:0] prod_s3;
	logic [SGN_W-1:0]  mag;
	logic [PROD_W-1:0] scaled;
	logic              rdy_o;

	assign rdy_o = !out_valid || out_ready;
	assign rdy3  = !valid_s3 || rdy_o;

	// Magnitude of the signed sum
	assign mag = res_s2.sgn_sum[SGN_W-1] ? SGN_W'(-res_s2.sgn_sum) : SGN_W'(res_s2.sgn_sum);

	// Square stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			abs_s3  <= res_s2.abs_sum;
			sq_s3   <= res_s2.sq_sum;
			prod_s3 <= mag * mag;
		end
	end

	// Divide by pixel count: shift by twice side_log2
	assign scaled = prod_s3 >> {side_log2, 1'b0};

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (rdy_o) begin
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && valid_s3) begin
			abs_diff_total <= abs_s3;
			sq_diff_total  <= sq_s3;
			block_variance <= sq_s3 - scaled[SQ_W-1:0];
		end
	end

endmodule

>>> sv/block_sad_sse_variance_core.sv
// Top level of the block SAD/SSE/variance core: input stage, lanes, merge, variance.
`timescale 1ns / 1ps

// Takes one item of four source and four predicted pixels per clock, in raster order, and
// after the last item of each square block (side 4, 8 or 16 from side_log2) gives SAD, SSE
// and variance as one result. Items stream at one per cycle when input does not stall; the lanes
// register their terms and the merge and accumulate work from those registers, so no loop
// limits the rate. After the block's last item is accepted, its result passes the block
// totals, square and output registers; these three result registers between the merge and
// the outputs let input continue while results wait, and input stalls only when all three
// hold results not yet taken and a block's last item is waiting in the input stage. Writing
// side_log2 (clamped to 2..log2 MAX_SIDE) restarts the block; write it only while the core
// is idle. LANES pixel lanes of the item are used; when LANES does not divide the pixel
// count, surplus lanes of the last item are ignored.
module block_sad_sse_variance_core #(
	parameter int LANES    = bssv_pkg::DEF_LANES,
	parameter int MAX_SIDE = bssv_pkg::DEF_MAX_SIDE
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bssv_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bssv_pkg::PIX_W-1:0]   src_pix0,
	input  logic [bssv_pkg::PIX_W-1:0]   src_pix1,
	input  logic [bssv_pkg::PIX_W-1:0]   src_pix2,
	input  logic [bssv_pkg::PIX_W-1:0]   src_pix3,
	input  logic [bssv_pkg::PIX_W-1:0]   pred_pix0,
	input  logic [bssv_pkg::PIX_W-1:0]   pred_pix1,
	input  logic [bssv_pkg::PIX_W-1:0]   pred_pix2,
	input  logic [bssv_pkg::PIX_W-1:0]   pred_pix3,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bssv_pkg::ABS_W-1:0]   abs_diff_total,
	output logic [bssv_pkg::SQ_W-1:0]    sq_diff_total,
	output logic [bssv_pkg::SQ_W-1:0]    block_variance
);
	import bssv_pkg::*;

	localparam int MAXL      = max_log2(MAX_SIDE);
	localparam int ITEMS_MAX = ((1 << (2 * MAXL)) + LANES - 1) / LANES;
	localparam int CNT_W     = $clog2(ITEMS_MAX);
	localparam int POS_W     = 2 * MAXL + 2;
	localparam logic [CFG_W-1:0] MAXL_V = CFG_W'(MAXL);
	localparam logic [CNT_W-1:0] LAST2  = CNT_W'(((1 << 4) + LANES - 1) / LANES - 1);
	localparam logic [CNT_W-1:0] LAST3  = CNT_W'(((1 << 6) + LANES - 1) / LANES - 1);
	localparam logic [CNT_W-1:0] LAST4  = CNT_W'(((1 << 8) + LANES - 1) / LANES - 1);

	logic [CFG_W-1:0] side_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] last_idx;
	logic [POS_W-1:0] pixels;
	logic [POS_W-1:0] done;
	logic             last_in;
	logic             valid_s1;
	logic             last_s1;
	logic             take_s1;
	logic             valid_s2;
	logic             rdy3;
	logic [PIX_W-1:0] src_a  [PORT_LANES];
	logic [PIX_W-1:0] pred_a [PORT_LANES];
	logic [LANES-1:0] use_lane;
	lane_res_t        lane_s1 [LANES];
	blk_res_t         res_s2;

	assign src_a[0]  = src_pix0;
	assign src_a[1]  = src_pix1;
	assign src_a[2]  = src_pix2;
	assign src_a[3]  = src_pix3;
	assign pred_a[0] = pred_pix0;
	assign pred_a[1] = pred_pix1;
	assign pred_a[2] = pred_pix2;
	assign pred_a[3] = pred_pix3;

	// Side register, clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= MAXL_V;
		end else if (cfg_we) begin
			if (cfg_data < MIN_SIDE_LOG2) begin
				side_q <= MIN_SIDE_LOG2;
			end else if (cfg_data > MAXL_V) begin
				side_q <= MAXL_V;
			end else begin
				side_q <= cfg_data;
			end
		end
	end

	// Block position of the incoming item
	always_comb begin
		unique case (side_q)
			3'd2:    last_idx = LAST2;
			3'd3:    last_idx = LAST3;
			default: last_idx = LAST4;
		endcase
		pixels  = POS_W'(1) << {side_q, 1'b0};
		done    = POS_W'(cnt_q) * POS_W'(LANES);
		last_in = (cnt_q == last_idx);
		for (int l = 0; l < LANES; l++) begin
			use_lane[l] = (done + POS_W'(l)) < pixels;
		end
	end

	// Input stage moves when empty or its item goes on
	assign in_ready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cnt_q <= '0;
			end else if (in_valid && in_ready) begin
				cnt_q <= last_in ? '0 : cnt_q + 1'b1;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
				last_s1  <= last_in;
			end
		end
	end

	// Pixel lanes
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		bssv_lane u_lane (
			.clk      (clk),
			.en       (in_ready),
			.use_lane (use_lane[g]),
			.src      (src_a[g]),
			.pred     (pred_a[g]),
			.res_s1   (lane_s1[g])
		);
	end

	// Merge and accumulate
	bssv_accum #(
		.LANES (LANES)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (cfg_we),
		.valid_s1  (valid_s1),
		.last_s1   (last_s1),
		.lane_s1   (lane_s1),
		.take_s1   (take_s1),
		.nxt_ready (rdy3),
		.valid_s2  (valid_s2),
		.res_s2    (res_s2)
	);

	// Variance and output register
	bssv_var u_var (
		.clk            (clk),
		.arst_n         (arst_n),
		.side_log2      (side_q),
		.valid_s2       (valid_s2),
		.res_s2         (res_s2),
		.rdy3           (rdy3),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.abs_diff_total (abs_diff_total),
		.sq_diff_total  (sq_diff_total),
		.block_variance (block_variance)
	);

endmodule

>>> tb/tb.sv
// Self-checking testbench for the block SAD/SSE/variance core.
`timescale 1ns / 1ps

module tb;
	import bssv_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 12;
	localparam int END_CYCLES   = 20;
	localparam int ITEM_TARGET  = 1900;
	localparam int MAX_REPORTS  = 50;

	// Pixel content styles for whole blocks
	typedef enum int {
		STY_RANDOM,
		STY_EQUAL,
		STY_NEAR,
		STY_POS_MAX,
		STY_NEG_MAX,
		STY_ALT_MAX,
		STY_EXTREME
	} pix_style_e;

	typedef struct packed {
		logic [PORT_LANES-1:0][PIX_W-1:0] src;
		logic [PORT_LANES-1:0][PIX_W-1:0] pred;
	} pix_item_t;

	typedef struct {
		logic [ABS_W-1:0] sad;
		logic [SQ_W-1:0]  sse;
		logic [SQ_W-1:0]  variance;
	} blk_totals_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [PIX_W-1:0]  src_pix0 = '0, src_pix1 = '0, src_pix2 = '0, src_pix3 = '0;
	logic [PIX_W-1:0]  pred_pix0 = '0, pred_pix1 = '0, pred_pix2 = '0, pred_pix3 = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [ABS_W-1:0]  abs_diff_total;
	logic [SQ_W-1:0]   sq_diff_total;
	logic [SQ_W-1:0]   block_variance;

	// Expected block totals, oldest first
	blk_totals_t totals_q[$];

	// Predictor state
	int unsigned sad_acc;
	int unsigned sse_acc;
	int          diff_acc;
	int          items_in_acc;
	int          side_cur = 4;

	int  err_count = 0;
	int  items_sent = 0;
	int  quiet_cycles = 0;
	int  ready_hold = 0;
	int  ready_roll;
	bit  no_idle = 1'b0;

	block_sad_sse_variance_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.src_pix0       (src_pix0),
		.src_pix1       (src_pix1),
		.src_pix2       (src_pix2),
		.src_pix3       (src_pix3),
		.pred_pix0      (pred_pix0),
		.pred_pix1      (pred_pix1),
		.pred_pix2      (pred_pix2),
		.pred_pix3      (pred_pix3),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.abs_diff_total (abs_diff_total),
		.sq_diff_total  (sq_diff_total),
		.block_variance (block_variance)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_REPORTS) begin
			$display("%0t mismatch: %s", $time, msg);
		end
		err_count++;
	endtask

	// Out-of-range side values clamp to 2..4
	function automatic int clamp_side(input logic [CFG_W-1:0] raw);
		if (raw < 3'd2) return 2;
		if (raw > 3'd4) return 4;
		return int'(raw);
	endfunction

	function automatic int items_per_side(input int side);
		return 1 << (2 * side - 2);
	endfunction

	// Add one item to the running totals; close the block when it is full
	task automatic accumulate_item(input pix_item_t it);
		int          s;
		int          p;
		int          d;
		longint      diff_sq;
		blk_totals_t t;
		for (int l = 0; l < PORT_LANES; l++) begin
			s = int'(it.src[l]);
			p = int'(it.pred[l]);
			d = s - p;
			sad_acc += (d < 0) ? -d : d;
			sse_acc += d * d;
			diff_acc += d;
		end
		items_in_acc++;
		if (items_in_acc == items_per_side(side_cur)) begin
			diff_sq = longint'(diff_acc) * longint'(diff_acc);
			t.sad = sad_acc[ABS_W-1:0];
			t.sse = sse_acc[SQ_W-1:0];
			t.variance = SQ_W'(longint'(sse_acc) - (diff_sq >> (2 * side_cur)));
			totals_q.push_back(t);
			sad_acc = 0;
			sse_acc = 0;
			diff_acc = 0;
			items_in_acc = 0;
		end
	endtask

	// Most gaps are zero or short, a few are long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic pix_item_t make_item(input pix_style_e sty);
		pix_item_t it;
		int        v;
		for (int l = 0; l < PORT_LANES; l++) begin
			it.src[l] = PIX_W'($urandom_range(0, 255));
			it.pred[l] = PIX_W'($urandom_range(0, 255));
			case (sty)
				STY_EQUAL: begin
					it.pred[l] = it.src[l];
				end
				STY_NEAR: begin
					v = int'(it.src[l]) + $urandom_range(0, 8) - 4;
					it.pred[l] = PIX_W'((v < 0) ? 0 : (v > 255) ? 255 : v);
				end
				STY_POS_MAX: begin
					it.src[l] = 8'hFF;
					it.pred[l] = 8'h00;
				end
				STY_NEG_MAX: begin
					it.src[l] = 8'h00;
					it.pred[l] = 8'hFF;
				end
				STY_ALT_MAX: begin
					it.src[l] = (l % 2 == 0) ? 8'hFF : 8'h00;
					it.pred[l] = ~it.src[l];
				end
				STY_EXTREME: begin
					it.src[l] = {PIX_W{$urandom_range(0, 1) == 1}};
					it.pred[l] = {PIX_W{$urandom_range(0, 1) == 1}};
				end
				default: begin
				end
			endcase
		end
		return it;
	endfunction

	// Offer one item, hold it until accepted, then maybe idle
	task automatic send_item(input pix_item_t it);
		int gap;
		in_valid <= 1'b1;
		src_pix0 <= it.src[0];
		src_pix1 <= it.src[1];
		src_pix2 <= it.src[2];
		src_pix3 <= it.src[3];
		pred_pix0 <= it.pred[0];
		pred_pix1 <= it.pred[1];
		pred_pix2 <= it.pred[2];
		pred_pix3 <= it.pred[3];
		do @(posedge clk); while (!in_ready);
		accumulate_item(it);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_items(input pix_style_e sty, input int n);
		for (int i = 0; i < n; i++) begin
			send_item(make_item(sty));
		end
	endtask

	// Write side_log2 once the core has drained; the write restarts the block
	task automatic write_side(input logic [CFG_W-1:0] raw);
		in_valid <= 1'b0;
		while (totals_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= raw;
		@(posedge clk);
		cfg_we <= 1'b0;
		side_cur = clamp_side(raw);
		sad_acc = 0;
		sse_acc = 0;
		diff_acc = 0;
		items_in_acc = 0;
	endtask

	// Reset side is 16x16; a saturated block hits the SAD and SSE maximum
	task automatic test_reset_side();
		send_items(STY_POS_MAX, items_per_side(4));
	endtask

	// 4x4 blocks at the pixel extremes and with zero, positive, negative and cancelling sums
	task automatic test_extremes();
		pix_item_t it;
		write_side(3'd2);
		it = '0;
		send_items(STY_RANDOM, 0);
		repeat (4) send_item(it);
		it = '1;
		repeat (4) send_item(it);
		send_items(STY_POS_MAX, 4);
		send_items(STY_NEG_MAX, 4);
		send_items(STY_ALT_MAX, 4);
	endtask

	// A write in the middle of a block drops the partial totals
	task automatic test_restart_on_write();
		write_side(3'd2);
		send_items(STY_RANDOM, 2);
		write_side(3'd3);
		send_items(STY_RANDOM, items_per_side(3));
		send_items(STY_RANDOM, 5);
		write_side(3'd2);
		send_items(STY_NEAR, 4);
	endtask

	// Every raw register value, including the ones that clamp
	task automatic test_side_clamp();
		logic [CFG_W-1:0] raws[8];
		raws = '{3'd0, 3'd1, 3'd7, 3'd5, 3'd6, 3'd3, 3'd2, 3'd4};
		foreach (raws[i]) begin
			write_side(raws[i]);
			send_items(STY_RANDOM, items_per_side(clamp_side(raws[i])));
		end
	endtask

	// Phases of whole blocks, mostly random content and now and then another style, some ending in a cut-off block
	task automatic test_random_phases();
		logic [CFG_W-1:0] raw;
		int               side;
		int               nblk;
		pix_style_e       sty;
		while (items_sent < ITEM_TARGET) begin
			raw = CFG_W'($urandom_range(0, 7));
			write_side(raw);
			side = clamp_side(raw);
			no_idle = ($urandom_range(0, 3) == 0);
			nblk = (side == 2) ? $urandom_range(3, 12) :
				(side == 3) ? $urandom_range(1, 4) : 1;
			repeat (nblk) begin
				sty = pix_style_e'($urandom_range(0, 9) > 6 ? $urandom_range(1, 6) : 0);
				send_items(sty, items_per_side(side));
			end
			if ($urandom_range(0, 3) == 0) begin
				send_items(STY_RANDOM, $urandom_range(1, items_per_side(side) - 1));
			end
		end
		no_idle = 1'b0;
	endtask

	// Receiver stalls: long runs of ready, short stalls, now and then a long one
	always @(posedge clk) begin
		ready_roll = $urandom_range(0, 99);
		if (no_idle) begin
			out_ready <= 1'b1;
			ready_hold <= 0;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (!out_ready) begin
			out_ready <= 1'b1;
			ready_hold <= $urandom_range(0, 15);
		end else if (ready_roll < 25) begin
			out_ready <= 1'b0;
			ready_hold <= (ready_roll < 3) ? $urandom_range(20, 60) : $urandom_range(0, 3);
		end
	end

	// Compare each accepted result with the oldest expected block totals
	always @(posedge clk) begin : check_totals
		blk_totals_t e;
		if (arst_n && out_valid && out_ready) begin
			if (totals_q.size() == 0) begin
				report_mismatch("result with no block pending");
			end else begin
				e = totals_q.pop_front();
				if (abs_diff_total !== e.sad)
					report_mismatch($sformatf("SAD %0d, expected %0d",
						abs_diff_total, e.sad));
				if (sq_diff_total !== e.sse)
					report_mismatch($sformatf("SSE %0d, expected %0d",
						sq_diff_total, e.sse));
				if (block_variance !== e.variance)
					report_mismatch($sformatf("variance %0d, expected %0d",
						block_variance, e.variance));
			end
		end
	end

	// Watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_side();
		test_extremes();
		test_restart_on_write();
		test_side_clamp();
		test_random_phases();
		in_valid <= 1'b0;
		while (totals_q.size() != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
